### sv/lio_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lio_pkg
// Shared types and codes for the LED indicator overlay compositor.
// ----------------------------------------------------------------------------
package lio_pkg;

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_STOP   = 3'd1,
		KIND_SET_ON = 3'd2,
		KIND_TICK   = 3'd3,
		KIND_RENDER = 3'd4
	} kind_t;

	localparam logic [1:0] EFFECT_SOLID = 2'd0;
	localparam logic [1:0] EFFECT_BLINK = 2'd1;
	localparam logic [1:0] MODE_BLACK   = 2'd0;
	localparam logic [1:0] MODE_TRANSP  = 2'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  led_base;
		logic [7:0]  led_span;
		logic [1:0]  effect;
		logic [1:0]  dark_mode;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic [31:0] lifetime_ms;
		logic [7:0]  priority_req;
		logic [23:0] color;
		logic [7:0]  led;
	} lio_in_t;

	typedef struct packed {
		logic        ok;
		logic        painted;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} lio_out_t;

	// one slot record as held in the slot memory
	typedef struct packed {
		logic [31:0] start_time;
		logic [7:0]  led_base;
		logic [7:0]  led_span;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic [31:0] duration;
		logic [7:0]  prio;
		logic [23:0] color;
		logic        blink;
		logic        transp;
	} slot_rec_t;

	// divider request and reply between sequencer and modulo unit
	typedef struct packed {
		logic        go;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] rem;
	} mod_rsp_t;

endpackage
`default_nettype wire

### sv/lio_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lio_mod
// Restoring bit-serial 32 by 17 bit remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lio_mod (
	input  wire               clk,
	input  wire               arst_n,
	input  wire lio_pkg::mod_req_t req,
	output lio_pkg::mod_rsp_t rsp
);
	import lio_pkg::*;

	logic [31:0] num_q;
	logic [16:0] den_q;
	logic [16:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;
	logic [17:0] diff;

	// shift in next dividend bit and try a subtract
	assign trial = {rem_q, num_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= diff[17] ? trial[16:0] : diff[16:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

### sv/led_indicator_overlay_compositor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_indicator_overlay_compositor
// Indicator slot table with tick expiry and per-LED priority render.
// ----------------------------------------------------------------------------
// Usage: drive an item on cmd and pulse start while busy is low. busy rises
// the next cycle and stays high until the single result beat is shown on rsp
// for exactly one cycle with done high; busy falls as done rises.
// Slot records live in a one-port synchronous memory with a registered read.
// Start, stop and set_on keep busy high while the slot is read (ST_WAIT),
// checked and written (ST_EVAL) and the result set up (ST_DONE). Tick keeps
// busy high while each slot is read and, if expired, its active bit cleared.
// Render reads each slot in turn, stopping after the first when led is out of
// range; an active, unexpired covering blink slot runs the bit-serial modulo
// unit, and the sequencer waits in ST_MOD until its remainder is done.
// Reset clears the active bits and the millisecond counter; slot records are
// not cleared and are only used for active slots. The receiver cannot stall:
// the result beat is lost if not sampled in its cycle.
// ----------------------------------------------------------------------------
module led_indicator_overlay_compositor #(
	parameter int SLOTS = 8,
	parameter int LEDS  = 128
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  wire lio_pkg::lio_in_t cmd,
	output logic             done,
	output lio_pkg::lio_out_t rsp
);
	import lio_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_WAIT = 7'b0000100,
		ST_EVAL = 7'b0001000,
		ST_MOD  = 7'b0010000,
		ST_NEXT = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t      state_q;
	lio_in_t     cmd_q;
	logic [31:0] now_q;
	logic [SLOTS-1:0] active_q;
	logic [SW-1:0]    idx_q;
	logic        ok_q, painted_q;
	logic [7:0]  best_q;
	logic [23:0] colour_q;

	// slot memory
	slot_rec_t mem [SLOTS];
	slot_rec_t rd_s1;
	logic      mem_we;
	logic [SW-1:0] mem_addr;
	slot_rec_t wr_rec;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= wr_rec;
		rd_s1 <= mem[mem_addr];
	end

	// start validation
	logic [8:0] range_end;
	logic       start_ok;
	logic       slot_valid;
	assign range_end  = {1'b0, cmd_q.led_base} + {1'b0, cmd_q.led_span};
	assign slot_valid = ({28'd0, cmd_q.slot} < 32'(SLOTS));
	assign start_ok = (cmd_q.led_span != 8'd0) && (32'(range_end) <= 32'(LEDS)) &&
		(cmd_q.effect == EFFECT_SOLID || cmd_q.effect == EFFECT_BLINK) &&
		!(cmd_q.effect == EFFECT_BLINK && (cmd_q.on_ms == 16'd0 || cmd_q.off_ms == 16'd0)) &&
		(cmd_q.dark_mode == MODE_BLACK || cmd_q.dark_mode == MODE_TRANSP);

	always_comb begin
		wr_rec.start_time = now_q;
		wr_rec.led_base   = cmd_q.led_base;
		wr_rec.led_span   = cmd_q.led_span;
		wr_rec.on_ms      = cmd_q.on_ms;
		wr_rec.off_ms     = cmd_q.off_ms;
		wr_rec.duration   = cmd_q.lifetime_ms;
		wr_rec.prio       = cmd_q.priority_req;
		wr_rec.color      = cmd_q.color;
		wr_rec.blink      = cmd_q.effect[0];
		wr_rec.transp     = cmd_q.dark_mode[0];
	end

	// per-slot evaluation on the read record
	logic [31:0] elapsed;
	logic        expired, covers;
	logic [8:0]  rd_end;
	assign elapsed = now_q - rd_s1.start_time;
	assign expired = (rd_s1.duration != 32'd0) && (elapsed >= rd_s1.duration);
	assign rd_end  = {1'b0, rd_s1.led_base} + {1'b0, rd_s1.led_span};
	assign covers  = (cmd_q.led >= rd_s1.led_base) && ({1'b0, cmd_q.led} < rd_end);

	mod_req_t mreq;
	mod_rsp_t mrsp;
	assign mreq.dividend = elapsed;
	assign mreq.divisor  = {1'b0, rd_s1.on_ms} + {1'b0, rd_s1.off_ms};

	lio_mod u_mod (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	logic cur_act;
	logic last_idx;
	assign cur_act  = active_q[idx_q];
	assign last_idx = (32'(idx_q) == SLOTS - 1);
	assign mem_addr = (state_q == ST_IDLE) ? cmd.slot[SW-1:0] : idx_q;
	assign mem_we   = (state_q == ST_EVAL) &&
		(cmd_q.kind == KIND_START || (cmd_q.kind == KIND_SET_ON && !cur_act)) &&
		slot_valid && start_ok;
	assign mreq.go  = (state_q == ST_EVAL) && (cmd_q.kind == KIND_RENDER) &&
		cur_act && covers && !expired && rd_s1.blink;

	// merge one slot into the render result
	logic        lit;
	logic        take;
	logic        merge_en;
	assign lit      = (state_q == ST_MOD) ? (mrsp.rem < {1'b0, rd_s1.on_ms}) : 1'b1;
	assign merge_en = ((state_q == ST_EVAL) && (cmd_q.kind == KIND_RENDER) && cur_act &&
		covers && !expired && !rd_s1.blink)
		|| ((state_q == ST_MOD) && mrsp.done);
	assign take     = merge_en && !(!lit && rd_s1.transp) && (!painted_q || rd_s1.prio >= best_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			now_q     <= '0;
			active_q  <= '0;
			idx_q     <= '0;
			ok_q      <= 1'b0;
			painted_q <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q     <= (cmd.kind == KIND_TICK || cmd.kind == KIND_RENDER) ?
							'0 : cmd.slot[SW-1:0];
						ok_q      <= 1'b0;
						painted_q <= 1'b0;
						if (cmd.kind == KIND_TICK) now_q <= now_q + 32'd1;
						state_q   <= ST_WAIT;
					end
				end
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_EVAL;
				ST_EVAL: begin
					case (cmd_q.kind)
						KIND_START, KIND_SET_ON: begin
							if (cmd_q.kind == KIND_SET_ON && slot_valid && cur_act) ok_q <= 1'b1;
							else if (mem_we) begin
								ok_q            <= 1'b1;
								active_q[idx_q] <= 1'b1;
							end
							state_q <= ST_DONE;
						end
						KIND_STOP: begin
							if (slot_valid) begin
								ok_q            <= 1'b1;
								active_q[idx_q] <= 1'b0;
							end
							state_q <= ST_DONE;
						end
						KIND_TICK: begin
							ok_q <= 1'b1;
							if (cur_act && expired) active_q[idx_q] <= 1'b0;
							state_q <= ST_NEXT;
						end
						KIND_RENDER: begin
							ok_q <= 1'b1;
							if (32'(cmd_q.led) >= 32'(LEDS)) state_q <= ST_DONE;
							else if (mreq.go) state_q <= ST_MOD;
							else state_q <= ST_NEXT;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_MOD: if (mrsp.done) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (last_idx) state_q <= ST_DONE;
					else begin
						idx_q   <= idx_q + SW'(1);
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take) painted_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) cmd_q <= cmd;
		if (take) begin
			best_q   <= rd_s1.prio;
			colour_q <= lit ? rd_s1.color : 24'd0;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign rsp.ok      = ok_q;
	assign rsp.painted = painted_q;
	assign rsp.red     = painted_q ? colour_q[23:16] : 8'd0;
	assign rsp.green   = painted_q ? colour_q[15:8]  : 8'd0;
	assign rsp.blue    = painted_q ? colour_q[7:0]   : 8'd0;

	// checks
	a_done_from_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE)) else $error("done without done state");
	a_no_write_outside_eval: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_EVAL)) else $error("slot write outside eval");
	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && cmd.kind == KIND_TICK) |=> now_q == $past(now_q) + 32'd1)
		else $error("tick did not advance counter");
	a_painted_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> !painted_q) else $error("painted not cleared");

endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED indicator overlay compositor: a queued
// command driver, a result monitor and a slot-table predictor compared beat
// by beat.
// ----------------------------------------------------------------------------
module tb;
	import lio_pkg::*;

	localparam int NSLOT = 8;
	localparam int NLED  = 128;
	localparam int WATCHDOG = 20000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	lio_in_t  cmd;
	logic     done;
	lio_out_t rsp;

	led_indicator_overlay_compositor #(.SLOTS(NSLOT), .LEDS(NLED)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	// predicted slot table
	logic [31:0] clock_ms;
	logic        act_q [NSLOT];
	logic [31:0] t0_q  [NSLOT];
	logic [7:0]  fst_q [NSLOT];
	logic [7:0]  cnt_q [NSLOT];
	logic [15:0] on_q  [NSLOT];
	logic [15:0] off_q [NSLOT];
	logic [31:0] dur_q [NSLOT];
	logic [7:0]  pri_q [NSLOT];
	logic [23:0] col_q [NSLOT];
	logic        blk_q [NSLOT];
	logic        trn_q [NSLOT];

	lio_in_t  cmd_q [$];
	lio_out_t pixel_q [$];
	int       errors;
	int       idle_cycles;
	bit       calm;
	bit       hold_drain;

	function automatic bit load_slot(lio_in_t c);
		int s;
		s = c.slot;
		if (c.led_span == 0 || int'(c.led_base) + int'(c.led_span) > NLED) return 0;
		if (c.effect > EFFECT_BLINK) return 0;
		if (c.effect == EFFECT_BLINK && (c.on_ms == 0 || c.off_ms == 0)) return 0;
		if (c.dark_mode > MODE_TRANSP) return 0;
		fst_q[s] = c.led_base; cnt_q[s] = c.led_span;
		on_q[s] = c.on_ms; off_q[s] = c.off_ms; dur_q[s] = c.lifetime_ms;
		pri_q[s] = c.priority_req; col_q[s] = c.color;
		blk_q[s] = c.effect[0]; trn_q[s] = c.dark_mode[0];
		t0_q[s] = clock_ms; act_q[s] = 1'b1;
		return 1;
	endfunction

	function automatic lio_out_t compose(lio_in_t c);
		lio_out_t r;
		logic [31:0] el;
		logic [7:0] top;
		logic lit;
		bit val;
		r = '0;
		val = c.slot < NSLOT;
		case (c.kind)
			KIND_START: r.ok = val && load_slot(c);
			KIND_STOP: if (val) begin
				act_q[c.slot] = 1'b0; r.ok = 1'b1;
			end
			KIND_SET_ON: if (val) r.ok = act_q[c.slot] ? 1'b1 : load_slot(c);
			KIND_TICK: begin
				clock_ms = clock_ms + 32'd1;
				for (int i = 0; i < NSLOT; i++)
					if (act_q[i] && dur_q[i] != 0 && clock_ms - t0_q[i] >= dur_q[i])
						act_q[i] = 1'b0;
				r.ok = 1'b1;
			end
			KIND_RENDER: begin
				r.ok = 1'b1;
				top = 8'd0;
				if (c.led < NLED) begin
					for (int i = 0; i < NSLOT; i++) begin
						if (!act_q[i]) continue;
						if (c.led < fst_q[i] || int'(c.led) >= int'(fst_q[i]) + int'(cnt_q[i]))
							continue;
						el = clock_ms - t0_q[i];
						if (dur_q[i] != 0 && el >= dur_q[i]) continue;
						lit = 1'b1;
						if (blk_q[i]) lit = (el % (33'(on_q[i]) + 33'(off_q[i]))) < on_q[i];
						if (!lit && trn_q[i]) continue;
						if (!r.painted || pri_q[i] >= top) begin
							r.painted = 1'b1;
							top = pri_q[i];
							{r.red, r.green, r.blue} = lit ? col_q[i] : 24'd0;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic lio_in_t rand_cmd(logic [2:0] k);
		lio_in_t c;
		c = '0;
		c.kind = k;
		c.slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
		if ($urandom_range(0, 9) == 0) begin
			c.led_base = 8'($urandom); c.led_span = 8'($urandom);
		end else begin
			c.led_base = 8'($urandom_range(0, 120));
			c.led_span = 8'($urandom_range(1, NLED - c.led_base));
		end
		c.effect = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
		c.dark_mode = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
		if ($urandom_range(0, 7) == 0) begin
			c.on_ms = 16'($urandom); c.off_ms = 16'($urandom);
		end else begin
			c.on_ms = 16'($urandom_range(0, 4)); c.off_ms = 16'($urandom_range(0, 4));
		end
		case ($urandom_range(0, 3))
			0: c.lifetime_ms = 32'd0;
			1: c.lifetime_ms = $urandom;
			default: c.lifetime_ms = $urandom_range(1, 20);
		endcase
		c.priority_req = ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 3));
		c.color = 24'($urandom);
		c.led = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// stimulus build
	initial begin
		lio_in_t c;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// directed: extremes, every kind, rejects
		c = rand_cmd(KIND_START); c.slot = 4'd0; c.led_base = 8'd0; c.led_span = 8'(NLED);
		c.effect = EFFECT_SOLID; c.dark_mode = MODE_BLACK; c.lifetime_ms = 32'd0;
		c.priority_req = 8'hff; c.color = 24'hffffff; cmd_q.push_back(c);
		c.kind = KIND_RENDER; c.led = 8'd0; cmd_q.push_back(c);
		c.led = 8'd127; cmd_q.push_back(c);
		c.led = 8'd128; cmd_q.push_back(c);
		c.led = 8'd255; cmd_q.push_back(c);
		c = rand_cmd(KIND_START); c.slot = 4'd7; c.led_base = 8'd10; c.led_span = 8'd5;
		c.effect = EFFECT_BLINK; c.dark_mode = MODE_BLACK; c.on_ms = 16'd2; c.off_ms = 16'd2;
		c.lifetime_ms = 32'd6; c.priority_req = 8'hff; c.color = 24'h123456; cmd_q.push_back(c);
		c.kind = KIND_SET_ON; cmd_q.push_back(c);
		for (int i = 0; i < 4; i++) begin
			c.kind = KIND_TICK; cmd_q.push_back(c);
			c.kind = KIND_RENDER; c.led = 8'd12; cmd_q.push_back(c);
		end
		c = rand_cmd(KIND_START); c.slot = 4'd3; c.led_span = 8'd0; cmd_q.push_back(c);
		c.led_span = 8'd1; c.led_base = 8'd200; cmd_q.push_back(c);
		c.led_base = 8'd0; c.effect = 2'd3; cmd_q.push_back(c);
		c.effect = EFFECT_BLINK; c.dark_mode = MODE_TRANSP; c.on_ms = 16'd0; c.off_ms = 16'd1;
		cmd_q.push_back(c);
		c.on_ms = 16'hffff; c.off_ms = 16'hffff; c.dark_mode = 2'd3; cmd_q.push_back(c);
		c.slot = 4'd15; c.dark_mode = MODE_TRANSP; cmd_q.push_back(c);
		c.kind = KIND_STOP; cmd_q.push_back(c);
		c.kind = 3'd7; cmd_q.push_back(c);
		c.kind = 3'd5; c.lifetime_ms = 32'hffffffff; cmd_q.push_back(c);
		c.kind = KIND_STOP; c.slot = 4'd0; cmd_q.push_back(c);
		// random: mostly start and render around ticking slots
		for (int n = 0; n < 450; n++) begin
			int p;
			logic [2:0] k;
			p = $urandom_range(0, 99);
			if (p < 25) k = KIND_START;
			else if (p < 32) k = KIND_STOP;
			else if (p < 42) k = KIND_SET_ON;
			else if (p < 62) k = KIND_TICK;
			else if (p < 97) k = KIND_RENDER;
			else k = 3'($urandom_range(5, 7));
			cmd_q.push_back(rand_cmd(k));
			if (n == 200) cmd_q.push_back('1);
		end
	end

	// driver
	int gap;
	initial begin
		start = 0; cmd = '0; gap = 0; calm = 0; hold_drain = 0;
	end
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && busy) begin
				// beat already taken, hold until busy falls
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (hold_drain && pixel_q.size() != 0) begin
				start <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				lio_in_t c;
				c = cmd_q.pop_front();
				if (c === '1) begin
					// drain marker: wait for all results before the next beat
					hold_drain <= 1'b1;
					start <= 1'b0;
				end else begin
					hold_drain <= 1'b0;
					cmd <= c;
					start <= 1'b1;
					if (!calm && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 8);
				end
				if (cmd_q.size() < 60) calm <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (start && !busy) pixel_q.push_back(compose(cmd));
			if (done) begin
				lio_out_t e;
				if (pixel_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10) $display("unexpected result beat %p", rsp);
				end else begin
					e = pixel_q.pop_front();
					if (rsp !== e) begin
						errors = errors + 1;
						if (errors <= 10)
							$display("mismatch: expected %p got %p", e, rsp);
					end
				end
			end
		end
	end

	initial begin
		errors = 0; idle_cycles = 0;
		for (int i = 0; i < NSLOT; i++) act_q[i] = 1'b0;
		clock_ms = '0;
		wait (arst_n);
		repeat (20) @(posedge clk);
		while ((cmd_q.size() != 0 || pixel_q.size() != 0 || start || busy)
		       && idle_cycles < WATCHDOG)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (idle_cycles >= WATCHDOG) begin
			$display("status: fail");
		end else if (errors == 0 && pixel_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
